/* sv/mrpw_pkg.sv */
// Package for the meter reading plausibility window.
// Holds the transaction structs, status and register codes, and the sequencer states.
// No dependencies.
package mrpw_pkg;

  localparam int VALUE_W       = 32;
  localparam int STAMP_W       = 32;
  localparam int WSIZE_W       = 5;
  localparam int STATUS_W      = 3;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int SEC_W         = 12;
  localparam int SCALED_W      = VALUE_W + SEC_W;
  localparam int PROD_W        = VALUE_W + STAMP_W;

  localparam logic [SEC_W-1:0]   SEC_PER_HOUR     = 12'd3600;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET      = 5'd5;
  localparam logic [VALUE_W-1:0] MAX_RATE_RESET   = 32'hFFFF_FFFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RATE    = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK,
    STS_BAD_FORMAT,
    STS_FILLING,
    STS_WIN_DROP,
    STS_WIN_RATE,
    STS_BELOW_LAST,
    STS_RATE_LAST
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCREEN,
    FSM_WALK,
    FSM_DRAIN,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic [VALUE_W-1:0] reading;
    logic [STAMP_W-1:0] timestamp;
    logic               format_ok;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic [STATUS_W-1:0] status;
    logic                checked_valid;
    logic [VALUE_W-1:0]  checked_value;
    logic [STAMP_W-1:0]  checked_time;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] reading;
    logic [STAMP_W-1:0] stamp;
  } cell_t;

  typedef struct packed {
    logic  valid;
    logic  vs_last;
    cell_t older;
    cell_t newer;
  } pair_req_t;

  typedef struct packed {
    logic valid;
    logic vs_last;
    logic drop;
    logic rate;
  } pair_res_t;

endpackage

/* sv/meter_reading_plausibility_window.sv */
// Meter reading plausibility window, top level: chain of MAX_WINDOW cells, sequencer,
// pair checker and output register. Uses mrpw_pkg, mrpw_cell and mrpw_pair_chk.
//
// One transaction in gives one transaction out. A reading with format_ok clear goes
// straight to the finish state, and one that leaves the window short of window_size
// finishes after the screen state. Once a value has been accepted, a full check
// rotates the chain once through all MAX_WINDOW cells past the single pair checker,
// one pair per cycle, then checks against the last accepted value and drains the
// checker pipeline. Before the first acceptance there is no check against the last
// value. The next input is taken as soon as the result sits in the output register,
// even while out_stall holds it. Configuration writes are taken at any time and must
// be made while no transaction is in flight.
module meter_reading_plausibility_window #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mrpw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mrpw_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [mrpw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mrpw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam logic [CW-1:0] MAXW = CW'(MAX_WINDOW);

  mrpw_pkg::fsm_t                   state_r, state_nxt;
  logic [mrpw_pkg::WSIZE_W-1:0]     wsize_r;
  logic [mrpw_pkg::VALUE_W-1:0]     max_rate_r;
  logic [CW-1:0]                    fill_r;
  logic [CW-1:0]                    step_r, step_nxt;
  mrpw_pkg::status_t                status_r, status_nxt;
  mrpw_pkg::cell_t                  prev_r;
  mrpw_pkg::cell_t                  cand_r;
  mrpw_pkg::cell_t                  last_r;
  logic                             have_last_r;
  logic                             out_valid_r;
  mrpw_pkg::out_item_t              out_data_r;

  mrpw_pkg::cell_t                  chain_q [MAX_WINDOW];
  mrpw_pkg::cell_t                  head_d;
  mrpw_pkg::cell_t                  tail;
  logic                             adv;
  logic                             take;
  logic                             insert;
  logic                             rotate;
  logic                             finish;
  logic [CW-1:0]                    ws;
  logic [CW-1:0]                    first_step;
  logic [CW-1:0]                    cand_step;
  mrpw_pkg::pair_req_t              req;
  mrpw_pkg::pair_res_t              res;
  logic                             chk_busy;
  logic                             pass;

  // window size clamp
  always_comb begin
    if (wsize_r == '0) begin
      ws = CW'(1);
    end else if (32'(wsize_r) > 32'(MAX_WINDOW)) begin
      ws = MAXW;
    end else begin
      ws = CW'(wsize_r);
    end
  end

  assign first_step = MAXW - ws + CW'(1);
  assign cand_step  = MAXW - ws + (ws >> 1);

  assign in_stall = (state_r != mrpw_pkg::FSM_IDLE);
  assign take     = in_valid && !in_stall;
  assign insert   = take && in_data.format_ok;
  assign tail     = chain_q[MAX_WINDOW-1];
  assign pass     = (status_r == mrpw_pkg::STS_OK);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    status_nxt = status_r;
    rotate     = 1'b0;
    finish     = 1'b0;
    req        = '0;
    req.older  = prev_r;
    req.newer  = tail;
    case (state_r)
      mrpw_pkg::FSM_IDLE: begin
        if (take) begin
          status_nxt = mrpw_pkg::STS_OK;
          if (in_data.format_ok) begin
            state_nxt = mrpw_pkg::FSM_SCREEN;
          end else begin
            status_nxt = mrpw_pkg::STS_BAD_FORMAT;
            state_nxt  = mrpw_pkg::FSM_FINISH;
          end
        end
      end
      mrpw_pkg::FSM_SCREEN: begin
        step_nxt = '0;
        if (fill_r < ws) begin
          status_nxt = mrpw_pkg::STS_FILLING;
          state_nxt  = mrpw_pkg::FSM_FINISH;
        end else begin
          state_nxt = mrpw_pkg::FSM_WALK;
        end
      end
      mrpw_pkg::FSM_WALK: begin
        if (step_r == MAXW) begin
          req.valid   = have_last_r;
          req.vs_last = 1'b1;
          req.older   = last_r;
          req.newer   = cand_r;
          state_nxt   = mrpw_pkg::FSM_DRAIN;
        end else begin
          rotate    = 1'b1;
          req.valid = (step_r >= first_step);
          step_nxt  = step_r + CW'(1);
        end
      end
      mrpw_pkg::FSM_DRAIN: begin
        if (!chk_busy && !res.valid) begin
          state_nxt = mrpw_pkg::FSM_FINISH;
        end
      end
      mrpw_pkg::FSM_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          finish    = 1'b1;
          state_nxt = mrpw_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = mrpw_pkg::FSM_IDLE;
      end
    endcase
    if (res.valid && pass) begin
      if (res.drop) begin
        status_nxt = res.vs_last ? mrpw_pkg::STS_BELOW_LAST : mrpw_pkg::STS_WIN_DROP;
      end else if (res.rate) begin
        status_nxt = res.vs_last ? mrpw_pkg::STS_RATE_LAST : mrpw_pkg::STS_WIN_RATE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrpw_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r    <= mrpw_pkg::WSIZE_RESET;
      max_rate_r <= mrpw_pkg::MAX_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrpw_pkg::CFG_WINDOW_SIZE: wsize_r    <= cfg_wdata[mrpw_pkg::WSIZE_W-1:0];
        mrpw_pkg::CFG_MAX_RATE:    max_rate_r <= cfg_wdata[mrpw_pkg::VALUE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      have_last_r <= 1'b0;
      last_r      <= '0;
      status_r    <= mrpw_pkg::STS_OK;
      step_r      <= '0;
    end else begin
      status_r <= status_nxt;
      step_r   <= step_nxt;
      if (insert && fill_r < MAXW) begin
        fill_r <= fill_r + CW'(1);
      end
      if (finish && pass) begin
        have_last_r <= 1'b1;
        last_r      <= cand_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mrpw_pkg::FSM_WALK) begin
      prev_r <= tail;
      if (step_r == cand_step) begin
        cand_r <= tail;
      end
    end
  end

  // reading chain: newest entry at cell 0, rotate through the tail for the walk
  assign adv = insert || rotate;

  always_comb begin
    if (insert) begin
      head_d.reading = in_data.reading;
      head_d.stamp   = in_data.timestamp;
    end else begin
      head_d = tail;
    end
  end

  mrpw_cell u_cell_head (
    .clk (clk),
    .adv (adv),
    .d   (head_d),
    .q   (chain_q[0])
  );

  for (genvar i = 1; i < MAX_WINDOW; i++) begin : g_chain
    mrpw_cell u_cell (
      .clk (clk),
      .adv (adv),
      .d   (chain_q[i-1]),
      .q   (chain_q[i])
    );
  end

  mrpw_pair_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .max_rate (max_rate_r),
    .req      (req),
    .res      (res),
    .busy     (chk_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r.accepted <= pass;
      out_data_r.status   <= status_r;
      if (pass) begin
        out_data_r.checked_valid <= 1'b1;
        out_data_r.checked_value <= cand_r.reading;
        out_data_r.checked_time  <= cand_r.stamp;
      end else begin
        out_data_r.checked_valid <= have_last_r;
        out_data_r.checked_value <= last_r.reading;
        out_data_r.checked_time  <= last_r.stamp;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/mrpw_cell.sv */
// One cell of the reading chain: holds one reading and its time stamp.
// Takes its neighbor's entry when the chain advances. Uses mrpw_pkg.
module mrpw_cell (
  input  logic            clk,
  input  logic            adv,
  input  mrpw_pkg::cell_t d,
  output mrpw_pkg::cell_t q
);

  mrpw_pkg::cell_t q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

/* sv/mrpw_pair_chk.sv */
// Pipelined pair checker: drop and rate test for one (older, newer) pair per cycle.
// Stage one forms differences, stage two the products, the result compares them.
// Uses mrpw_pkg.
module mrpw_pair_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mrpw_pkg::VALUE_W-1:0]   max_rate,
  input  mrpw_pkg::pair_req_t            req,
  output mrpw_pkg::pair_res_t            res,
  output logic                           busy
);

  logic                            a_valid_r;
  logic                            a_last_r;
  logic                            a_drop_r;
  logic                            a_neg_r;
  logic [mrpw_pkg::VALUE_W-1:0]    a_dv_r;
  logic [mrpw_pkg::STAMP_W-1:0]    a_dt_r;

  logic                            b_valid_r;
  logic                            b_last_r;
  logic                            b_drop_r;
  logic                            b_neg_r;
  logic [mrpw_pkg::SCALED_W-1:0]   b_pa_r;
  logic [mrpw_pkg::PROD_W-1:0]     b_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= req.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_last_r <= req.vs_last;
    a_drop_r <= req.newer.reading < req.older.reading;
    a_neg_r  <= req.newer.stamp < req.older.stamp;
    a_dv_r   <= req.newer.reading - req.older.reading;
    a_dt_r   <= req.newer.stamp - req.older.stamp;

    b_last_r <= a_last_r;
    b_drop_r <= a_drop_r;
    b_neg_r  <= a_neg_r;
    b_pa_r   <= mrpw_pkg::SCALED_W'(a_dv_r) * mrpw_pkg::SCALED_W'(mrpw_pkg::SEC_PER_HOUR);
    b_pb_r   <= mrpw_pkg::PROD_W'(max_rate) * mrpw_pkg::PROD_W'(a_dt_r);
  end

  always_comb begin
    res.valid   = b_valid_r;
    res.vs_last = b_last_r;
    res.drop    = b_drop_r;
    res.rate    = !b_drop_r && !b_neg_r && (mrpw_pkg::PROD_W'(b_pa_r) > b_pb_r);
  end

  assign busy = a_valid_r || b_valid_r;

endmodule
